// ----- hw/rtl/rfp_pkg.sv -----
package rfp_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES   = 9;
  localparam int unsigned PAYLOAD_BYTES = FRAME_BYTES - 3;
  localparam int unsigned CHECK_POS     = FRAME_BYTES - 1;
  localparam int unsigned SLOT_W        = $clog2(PAYLOAD_BYTES);

  // register map and reset values
  localparam logic       REG_HEADER   = 1'b0;
  localparam logic       REG_THRESH   = 1'b1;
  localparam logic [7:0]  HEADER_RESET = 8'd89;
  localparam logic [15:0] THRESH_RESET = 16'd100;

  // temperature conversion: raw*100/8 - 25600
  localparam logic [6:0]  TEMP_SCALE  = 7'd100;
  localparam int unsigned TEMP_SHIFT  = 3;
  localparam logic [15:0] TEMP_OFFSET = 16'd25600;

  // strength that marks a saturated return
  localparam logic [15:0] STRENGTH_SAT = 16'hFFFF;

  typedef logic [PAYLOAD_BYTES-1:0][7:0] payload_t;

  typedef struct packed {
    logic [15:0]        range_cm;
    logic [15:0]        signal_strength;
    logic signed [15:0] temp_centideg;
    logic               reading_valid;
  } reading_t;

endpackage

// ----- hw/rtl/rfp_conv.sv -----
module rfp_conv (
  input  rfp_pkg::payload_t payload,
  input  logic [15:0]       strength_threshold,
  output rfp_pkg::reading_t reading
);
  import rfp_pkg::*;

  logic [15:0] range_val;
  logic [15:0] strength;
  logic [15:0] raw_temp;
  logic [22:0] temp_prod;
  logic [19:0] temp_scaled;

  // little-endian byte pairs
  assign range_val = {payload[1], payload[0]};
  assign strength  = {payload[3], payload[2]};
  assign raw_temp  = {payload[5], payload[4]};

  // scale to centidegrees, divide by 8, remove offset, wrap to 16 bits
  assign temp_prod   = {7'd0, raw_temp} * {16'd0, TEMP_SCALE};
  assign temp_scaled = temp_prod[22:TEMP_SHIFT];

  always_comb begin
    reading.range_cm        = range_val;
    reading.signal_strength = strength;
    reading.temp_centideg   = signed'(temp_scaled[15:0] - TEMP_OFFSET);
    reading.reading_valid   = (strength >= strength_threshold) && (strength != STRENGTH_SAT);
  end

endmodule

// ----- hw/rtl/rangefinder_frame_parser.sv -----
// a reading appears on the master side in the cycle after its checksum byte is taken
// throughput: one received byte per cycle; the single output register lets a byte in
//   while a reading waits, and only a stalled reading plus a checksum byte stalls input
// reset: parser back to header hunt, sum, position, frame counter and output valid cleared,
//   header_byte back to 89 and strength_threshold back to 100
module rangefinder_frame_parser (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // received bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_data
  // readings
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [15:0] range_cm, [31:16] signal_strength,
                                 // [47:32] temp_centideg, [79:48] frame_count
  output logic [0:0]  m_tuser    // [0] reading_valid
);
  import rfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_HDR2 = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  logic [7:0]  header_byte;
  logic [15:0] strength_threshold;

  phase_t      phase, phase_next;
  logic [3:0]  byte_pos, byte_pos_next;
  logic [7:0]  run_sum, run_sum_next;
  payload_t    payload;
  logic [31:0] frame_count;

  logic        s_fire;
  logic        cfg_write;
  logic        emit;
  logic        check_byte;
  logic        store_en;
  logic [SLOT_W-1:0] store_slot;
  reading_t    reading;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte        <= HEADER_RESET;
      strength_threshold <= THRESH_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_HEADER: header_byte        <= pwdata[7:0];
        REG_THRESH: strength_threshold <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HEADER: prdata = {24'd0, header_byte};
      REG_THRESH: prdata = {16'd0, strength_threshold};
      default:    prdata = 32'd0;
    endcase
  end

  // only a checksum byte can produce a reading, so only it waits for the output register
  assign check_byte = (phase == PH_BODY) && (byte_pos >= 4'(CHECK_POS));
  assign s_tready   = !m_tvalid || m_tready || !check_byte;
  assign s_fire     = s_tvalid && s_tready;

  // frame parser
  always_comb begin
    phase_next    = phase;
    byte_pos_next = byte_pos;
    run_sum_next  = run_sum;
    emit          = 1'b0;
    store_en      = 1'b0;
    store_slot    = SLOT_W'(byte_pos - 4'd2);
    case (phase)
      PH_HUNT: begin
        if (s_tdata == header_byte) begin
          run_sum_next  = s_tdata;
          byte_pos_next = 4'd1;
          phase_next    = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (s_tdata == header_byte) begin
          run_sum_next  = run_sum + s_tdata;
          byte_pos_next = 4'd2;
          phase_next    = PH_BODY;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (byte_pos < 4'(CHECK_POS)) begin
          store_en      = (byte_pos >= 4'd2);
          run_sum_next  = run_sum + s_tdata;
          byte_pos_next = byte_pos + 4'd1;
        end else begin
          emit          = (run_sum == s_tdata);
          phase_next    = PH_HUNT;
          byte_pos_next = 4'd0;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      byte_pos <= 4'd0;
      run_sum  <= 8'd0;
    end else if (s_fire) begin
      phase    <= phase_next;
      byte_pos <= byte_pos_next;
      run_sum  <= run_sum_next;
    end
  end

  // payload bytes of the current frame
  always_ff @(posedge clk) begin
    if (s_fire && store_en) begin
      payload[store_slot] <= s_tdata;
    end
  end

  rfp_conv u_conv (
    .payload            (payload),
    .strength_threshold (strength_threshold),
    .reading            (reading)
  );

  // good frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= 32'd0;
    end else if (s_fire && emit) begin
      frame_count <= frame_count + 32'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && emit) begin
      m_tdata <= {frame_count + 32'd1, reading.temp_centideg,
                  reading.signal_strength, reading.range_cm};
      m_tuser <= reading.reading_valid;
    end
  end

  // checks
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (s_fire && emit) |=> (frame_count == $past(frame_count) + 32'd1))
    else $error("frame counter did not advance by one on a good frame");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && check_byte) |-> !s_tready)
    else $error("checksum byte taken while a reading is stalled");

  a_body_position: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (byte_pos >= 4'd2 && byte_pos <= 4'(CHECK_POS)))
    else $error("frame byte position out of range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_fire && phase == PH_BODY && byte_pos == 4'(CHECK_POS)))
    else $error("reading produced without a checksum byte");

endmodule

// ----- bench/rangefinder_frame_parser_test.sv -----
`timescale 1ns / 1ps
module rangefinder_frame_parser_test;
  import rfp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, COLLECT, PHASE_SPARE} parse_phase_t;

  typedef struct {
    logic [15:0] distance;
    logic [15:0] strength;
    logic [15:0] temp;
    logic        valid;
    logic [31:0] count;
  } reading_exp_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] rx_data
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;   // [15:0] range_cm, [31:16] signal_strength,
                          // [47:32] temp_centideg, [79:48] frame_count
  logic [0:0]  m_tuser;   // [0] reading_valid

  // expected readings, oldest first
  reading_exp_t readings_due[$];

  // parser mirror
  parse_phase_t phase;
  logic [3:0]   position;
  logic [7:0]   frame_sum;
  logic [7:0]   payload [0:5];
  logic [31:0]  frames_seen;
  logic [7:0]   header_cfg;
  logic [15:0]  thresh_cfg;

  int errors;
  int cycles;
  int bytes_sent;
  bit steady;

  rangefinder_frame_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rangefinder_frame_parser_test failed");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  // advance the parser mirror by one received byte
  function automatic void parse_byte(input logic [7:0] b);
    logic [15:0]  strength;
    logic [15:0]  raw;
    logic [31:0]  scaled;
    reading_exp_t r;
    int           slot;
    case (phase)
      HUNT_FIRST: begin
        if (b == header_cfg) begin
          frame_sum = b;
          position = 4'd1;
          phase = HUNT_SECOND;
        end
      end
      HUNT_SECOND: begin
        if (b == header_cfg) begin
          frame_sum = frame_sum + b;
          position = 4'd2;
          phase = COLLECT;
        end else begin
          phase = HUNT_FIRST;
        end
      end
      COLLECT: begin
        if (position < 4'(CHECK_POS)) begin
          slot = int'(position) - 2;
          if (slot >= 0 && slot < int'(PAYLOAD_BYTES)) payload[slot] = b;
          frame_sum = frame_sum + b;
          position = position + 4'd1;
        end else begin
          // checksum byte closes the frame either way
          if (frame_sum == b) begin
            strength = {payload[3], payload[2]};
            raw = {payload[5], payload[4]};
            scaled = ({16'd0, raw} * 32'd100) / 32'd8;
            frames_seen = frames_seen + 32'd1;
            r.distance = {payload[1], payload[0]};
            r.strength = strength;
            r.temp = scaled[15:0] - 16'd25600;
            r.valid = (strength >= thresh_cfg) && (strength != 16'hFFFF);
            r.count = frames_seen;
            readings_due.push_back(r);
          end
          phase = HUNT_FIRST;
          position = 4'd0;
        end
      end
      default: phase = HUNT_FIRST;
    endcase
  endfunction

  // reading sink with random backpressure
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 15);
  end

  // compare each accepted reading with the oldest expectation
  always @(posedge clk) begin : check_readings
    reading_exp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (readings_due.size() == 0) begin
        report("unexpected reading, frame_count", m_tdata[79:48], 32'd0);
      end else begin
        want = readings_due.pop_front();
        if (m_tdata[15:0] !== want.distance)
          report("range_cm", 32'(m_tdata[15:0]), 32'(want.distance));
        if (m_tdata[31:16] !== want.strength)
          report("signal_strength", 32'(m_tdata[31:16]), 32'(want.strength));
        if (m_tdata[47:32] !== want.temp)
          report("temp_centideg", 32'(m_tdata[47:32]), 32'(want.temp));
        if (m_tuser[0] !== want.valid)
          report("reading_valid", 32'(m_tuser[0]), 32'(want.valid));
        if (m_tdata[79:48] !== want.count)
          report("frame_count", m_tdata[79:48], want.count);
      end
    end
  end

  // one received byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // hold input until every expected reading has left the block
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_HEADER) header_cfg = value[7:0];
    else thresh_cfg = value[15:0];
    @(negedge clk);
  endtask

  // payload is {raw temp, strength, distance}, byte 0 lowest
  task automatic send_frame(input logic [7:0] hdr, input logic [47:0] body, input bit good);
    logic [7:0] sum;
    sum = hdr + hdr;
    for (int i = 0; i < 6; i++) sum = sum + body[8*i +: 8];
    send_byte(hdr);
    send_byte(hdr);
    for (int i = 0; i < 6; i++) send_byte(body[8*i +: 8]);
    send_byte(good ? sum : sum + 8'($urandom_range(1, 255)));
  endtask

  function automatic logic [15:0] pick_strength();
    case ($urandom_range(3))
      0: return thresh_cfg;
      1: return thresh_cfg - 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // reset register values, field extremes and the threshold boundary
  task automatic test_default_frames();
    send_frame(header_cfg, {16'h0000, 16'd100, 16'h0000}, 1'b1);
    send_frame(header_cfg, {16'hFFFF, 16'd99, 16'hFFFF}, 1'b1);
    send_frame(header_cfg, {16'h5678, 16'hFFFF, 16'h1234}, 1'b1);
    send_frame(header_cfg, {16'h0CCD, 16'hFFFE, 16'h00FF}, 1'b1);
    send_frame(header_cfg, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_frame(header_cfg, 48'h0000_0000_0000, 1'b1);
  endtask

  // broken header, bad checksum, extra header, header value in payload
  task automatic test_broken_frames();
    send_byte(header_cfg);
    send_byte(~header_cfg);
    send_frame(header_cfg, {16'h0800, 16'd500, 16'd1000}, 1'b1);
    send_frame(header_cfg, {16'h0900, 16'd600, 16'd2000}, 1'b0);
    send_frame(header_cfg, {16'h0A00, 16'd700, 16'd3000}, 1'b1);
    send_byte(header_cfg);
    send_frame(header_cfg, {16'h0B00, 16'd800, 16'd4000}, 1'b1);
    send_frame(header_cfg, {16'h0C00, 16'd900, 16'd5000}, 1'b1);
    send_frame(header_cfg, {{2{header_cfg}}, {2{header_cfg}}, {2{header_cfg}}}, 1'b1);
  endtask

  // both registers at their extremes
  task automatic test_register_extremes();
    write_reg(REG_HEADER, 32'h0000_0000);
    write_reg(REG_THRESH, 32'h0000_0000);
    send_frame(8'h00, {16'h0100, 16'h0000, 16'h0042}, 1'b1);
    send_frame(8'h00, {16'h0200, 16'hFFFF, 16'h0043}, 1'b1);
    send_frame(8'h00, 48'h0, 1'b1);
    write_reg(REG_HEADER, 32'h0000_00FF);
    write_reg(REG_THRESH, 32'h0000_FFFF);
    send_byte(8'd89);
    send_frame(8'hFF, {16'h0300, 16'hFFFF, 16'h0044}, 1'b1);
    send_frame(8'hFF, {16'h0400, 16'hFFFE, 16'hFFFF}, 1'b1);
    send_frame(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b1);
  endtask

  // mostly well-formed frames with random content, some bad checksums and noise
  task automatic test_random_traffic(input int n_bytes, input bit no_idle, input bit pause);
    int  stop_at;
    int  half_at;
    bit  paused;
    int  pick;
    write_reg(REG_HEADER, $urandom());
    write_reg(REG_THRESH, ($urandom_range(3) == 0) ? 32'($urandom_range(255)) : $urandom());
    steady = no_idle;
    paused = 1'b0;
    stop_at = bytes_sent + n_bytes;
    half_at = bytes_sent + n_bytes / 2;
    while (bytes_sent < stop_at) begin
      if (pause && !paused && bytes_sent >= half_at) begin
        wait_idle();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(header_cfg, {16'($urandom()), pick_strength(), 16'($urandom())}, 1'b1);
      end else if (pick < 80) begin
        send_frame(header_cfg, {16'($urandom()), pick_strength(), 16'($urandom())}, 1'b0);
      end else if (pick < 88) begin
        send_byte(header_cfg);
        send_byte(header_cfg ^ 8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom()));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    steady = 1'b0;
    errors = 0;
    cycles = 0;
    bytes_sent = 0;
    header_cfg = HEADER_RESET;
    thresh_cfg = THRESH_RESET;
    phase = HUNT_FIRST;
    position = '0;
    frame_sum = '0;
    frames_seen = '0;
    for (int i = 0; i < 6; i++) payload[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_frames();
    test_broken_frames();
    test_register_extremes();
    test_random_traffic(400, 1'b0, 1'b0);
    test_random_traffic(400, 1'b1, 1'b0);
    test_random_traffic(400, 1'b0, 1'b1);
    test_random_traffic(400, 1'b0, 1'b0);

    wait_idle();
    repeat (10) @(negedge clk);
    if (readings_due.size() != 0)
      report("readings left over", 32'(readings_due.size()), 32'd0);
    if (errors == 0) begin
      $display("rangefinder_frame_parser_test passed");
    end else begin
      $display("rangefinder_frame_parser_test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rfp_pkg.sv
hw/rtl/rfp_conv.sv
hw/rtl/rangefinder_frame_parser.sv
bench/rangefinder_frame_parser_test.sv
